// ----- sv/open_loop_foc_phase_duty_defines.svh -----
// ---------------------------------------------------------------------------
// Open-loop FOC phase duty: assertion macros
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef OPEN_LOOP_FOC_PHASE_DUTY_DEFINES_SVH
`define OPEN_LOOP_FOC_PHASE_DUTY_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OLFOC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("olfoc same-cycle check failed");

// next-cycle implication, disabled in reset
`define OLFOC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("olfoc next-cycle check failed");

`endif

// ----- sv/olfoc_pkg.sv -----
// ---------------------------------------------------------------------------
// Open-loop FOC phase duty: package
// Widths, register indexes, fixed-point constants and the quarter-wave table.
// ---------------------------------------------------------------------------
package olfoc_pkg;

  localparam int SINE_TABLE_BITS = 8;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;

  localparam int VOLT_W = 26;
  localparam int FULL_W = 22;
  localparam int DUTY_W = 8;
  localparam int DT_W   = 19;
  localparam int MOP_W  = 33;
  localparam int PROD_W = 2 * MOP_W;

  localparam logic [1:0] REG_SUPPLY = 2'd0;
  localparam logic [1:0] REG_DLIM   = 2'd1;
  localparam logic [1:0] REG_PPC    = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  localparam logic [5:0]  SUPPLY_RST = 6'd12;
  localparam logic [5:0]  DLIM_RST   = 6'd6;
  localparam logic [5:0]  PPC_RST    = 6'd7;

  localparam logic [31:0] DT_MAX     = 32'd500000;
  localparam logic [DT_W-1:0] DT_DEFAULT = DT_W'(1000);

  localparam logic signed [MOP_W-1:0] TURN_K    = MOP_W'(44798134);
  localparam logic signed [MOP_W-1:0] SQRT3_Q16 = MOP_W'(113512);

  localparam longint C1 = 64'sd1686629713;
  localparam longint C3 = -64'sd693598670;
  localparam longint C5 = 64'sd85569306;
  localparam longint C7 = -64'sd5026996;
  localparam longint C9 = 64'sd172273;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef logic [16:0] sine_tab_t [0:SINE_N];

  function automatic longint mul_q30(input longint a, input longint b);
    logic   neg;
    longint ua;
    longint ub;
    longint p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = (ua * ub) >>> 30;
    return neg ? -p : p;
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    longint    x;
    longint    x2;
    longint    acc;
    for (int i = 0; i <= SINE_N; i++) begin
      x   = longint'(i) <<< (30 - SINE_TABLE_BITS);
      x2  = mul_q30(x, x);
      acc = C9;
      acc = C7 + mul_q30(acc, x2);
      acc = C5 + mul_q30(acc, x2);
      acc = C3 + mul_q30(acc, x2);
      acc = C1 + mul_q30(acc, x2);
      acc = mul_q30(acc, x);
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 8192) >>> 14;
      if (acc > 65536) begin
        acc = 65536;
      end
      t[i] = acc[16:0];
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic logic signed [17:0] sine_q16(input logic [31:0] ang);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS:0]   pos;
    logic [16:0]                mag;
    idx = ang[29 -: SINE_TABLE_BITS];
    pos = ang[30] ? ((SINE_TABLE_BITS+1)'(SINE_N) - {1'b0, idx}) : {1'b0, idx};
    mag = SINE_TAB[pos];
    return ang[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// ----- sv/olfoc_div.sv -----
// ---------------------------------------------------------------------------
// Open-loop FOC phase duty: duty divider
// Clamps one phase voltage to 0..full and forms clamp*255/full with a
// restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module olfoc_div (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic signed [olfoc_pkg::VOLT_W-1:0]      volt,
  input  logic        [olfoc_pkg::FULL_W-1:0]      full,
  output olfoc_pkg::div_stat_t                     stat,
  output logic        [olfoc_pkg::DUTY_W-1:0]      duty
);
  import olfoc_pkg::*;

  localparam int NUM_W = FULL_W + DUTY_W;
  localparam int DEN_W = FULL_W + DUTY_W - 1;
  localparam int CNT_W = $clog2(DUTY_W);

  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DUTY_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              zero_r;
  logic [FULL_W-1:0] clip;
  logic [NUM_W-1:0]  num_init;
  logic              ge;

  always_comb begin
    if (volt < 0) begin
      clip = '0;
    end else if (volt > $signed({{(VOLT_W-FULL_W){1'b0}}, full})) begin
      clip = full;
    end else begin
      clip = volt[FULL_W-1:0];
    end
    num_init = {clip, {DUTY_W{1'b0}}} - {{DUTY_W{1'b0}}, clip};
    ge       = num_r >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DUTY_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num_init;
      den_r  <= {full, {(DUTY_W-1){1'b0}}};
      q_r    <= '0;
      zero_r <= (full == '0);
    end else if (busy_r) begin
      if (ge) begin
        num_r <= num_r - {1'b0, den_r};
      end
      q_r   <= {q_r[DUTY_W-2:0], ge};
      den_r <= den_r >> 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign duty      = zero_r ? '0 : q_r;

endmodule

// ----- sv/open_loop_foc_phase_duty.sv -----
// ---------------------------------------------------------------------------
// Open-loop FOC phase duty generator
// Advances a stored shaft angle per control tick and turns the open-loop
// quadrature voltage into three 8-bit PWM duties.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transaction per control tick with a
// signed Q16.16 velocity and the elapsed microseconds. Output channel
// (out_valid/out_ready): three phase duties and the applied Uq.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 supply,
// 1 drive limit, 2 pole pairs, 3 zero offset); write only while idle.
// A single 33x33 multiplier serves the angle step, the electrical angle, the
// inverse Park and the sqrt3 scaling, then a bit-per-cycle divider forms the
// three duties in turn. out_valid rises in the same cycle that in_ready returns,
// and a new tick is taken only after the last result is in the output register.
// Reset clears the shaft angle and loads the register defaults (12 V supply,
// 6 V limit, 7 pole pairs, zero offset).
// A stalled receiver holds the result in the output register; the next tick
// is still accepted and computed, and waits only at its final output load.
// ---------------------------------------------------------------------------
module open_loop_foc_phase_duty (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_target_velocity,
  input  logic [31:0] in_elapsed_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_duty_phase_a,
  output logic [7:0]  out_duty_phase_b,
  output logic [7:0]  out_duty_phase_c,
  output logic [5:0]  out_applied_uq,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import olfoc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RATE   = 4'd1;
  localparam logic [3:0] S_LO     = 4'd2;
  localparam logic [3:0] S_HI     = 4'd3;
  localparam logic [3:0] S_ADV    = 4'd4;
  localparam logic [3:0] S_ELEC   = 4'd5;
  localparam logic [3:0] S_ANG    = 4'd6;
  localparam logic [3:0] S_SIN    = 4'd7;
  localparam logic [3:0] S_COS    = 4'd8;
  localparam logic [3:0] S_UB     = 4'd9;
  localparam logic [3:0] S_S3     = 4'd10;
  localparam logic [3:0] S_S3B    = 4'd11;
  localparam logic [3:0] S_SUM    = 4'd12;
  localparam logic [3:0] S_DSTART = 4'd13;
  localparam logic [3:0] S_DWAIT  = 4'd14;
  localparam logic [3:0] S_OUT    = 4'd15;

  localparam logic [31:0] QUARTER = 32'h4000_0000;

  logic [3:0]  state_r;
  logic [3:0]  state_nxt;

  logic [5:0]  supply_r;
  logic [5:0]  dlim_r;
  logic [5:0]  ppc_r;
  logic [15:0] offset_r;
  logic [31:0] mech_angle_r;

  logic [31:0]                vel_r;
  logic [DT_W-1:0]            dt_r;
  logic [DT_W-1:0]            dt_sel;
  logic [31:0]                rate_hi_r;
  logic [31:0]                step_hi_r;
  logic [31:0]                el_r;
  logic signed [17:0]         tab_r;
  logic signed [VOLT_W-1:0]   ualpha_r;
  logic signed [VOLT_W-1:0]   s3b_r;
  logic signed [VOLT_W-1:0]   ph_r [0:2];
  logic [DUTY_W-1:0]          duty_r [0:2];
  logic [1:0]                 div_idx_r;

  logic signed [MOP_W-1:0]    mul_a;
  logic signed [MOP_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   mul_p_r;
  logic signed [PROD_W-1:0]   prod_adj;

  logic signed [VOLT_W-1:0]   half_v;
  logic signed [VOLT_W-1:0]   diff_b;
  logic signed [VOLT_W-1:0]   diff_c;
  logic signed [VOLT_W-1:0]   ph_a_nxt;
  logic signed [VOLT_W-1:0]   ph_b_nxt;
  logic signed [VOLT_W-1:0]   ph_c_nxt;

  logic                       out_valid_r;
  logic [DUTY_W-1:0]          out_a_r;
  logic [DUTY_W-1:0]          out_b_r;
  logic [DUTY_W-1:0]          out_c_r;
  logic [5:0]                 out_uq_r;

  logic                       in_take;
  logic                       out_load;
  logic                       div_start;
  div_stat_t                  div_stat;
  logic [DUTY_W-1:0]          div_duty;

  assign in_ready  = (state_r == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign div_start = (state_r == S_DSTART) && !div_stat.busy;

  always_comb begin
    if (in_elapsed_us == 32'd0 || in_elapsed_us > DT_MAX) begin
      dt_sel = DT_DEFAULT;
    end else begin
      dt_sel = in_elapsed_us[DT_W-1:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_RATE: begin
        mul_a = {vel_r[31], vel_r};
        mul_b = TURN_K;
      end
      S_LO: begin
        mul_a = {1'b0, mul_p_r[31:0]};
        mul_b = {{(MOP_W-DT_W){1'b0}}, dt_r};
      end
      S_HI: begin
        mul_a = {1'b0, rate_hi_r};
        mul_b = {{(MOP_W-DT_W){1'b0}}, dt_r};
      end
      S_ELEC: begin
        mul_a = {1'b0, mech_angle_r};
        mul_b = {{(MOP_W-6){1'b0}}, ppc_r};
      end
      S_COS, S_UB: begin
        mul_a = {{(MOP_W-6){1'b0}}, dlim_r};
        mul_b = {{(MOP_W-18){tab_r[17]}}, tab_r};
      end
      S_S3: begin
        mul_a = SQRT3_Q16;
        mul_b = mul_p_r[MOP_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prod_adj = mul_p_r + (mul_p_r[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    half_v   = $signed({{(VOLT_W-21){1'b0}}, supply_r, 15'b0});
    diff_b   = s3b_r - ualpha_r;
    diff_c   = -ualpha_r - s3b_r;
    ph_a_nxt = ualpha_r + half_v;
    ph_b_nxt = ((diff_b + $signed({{(VOLT_W-1){1'b0}}, diff_b[VOLT_W-1]})) >>> 1) + half_v;
    ph_c_nxt = ((diff_c + $signed({{(VOLT_W-1){1'b0}}, diff_c[VOLT_W-1]})) >>> 1) + half_v;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_take) state_nxt = S_RATE;
      S_RATE:   state_nxt = S_LO;
      S_LO:     state_nxt = S_HI;
      S_HI:     state_nxt = S_ADV;
      S_ADV:    state_nxt = S_ELEC;
      S_ELEC:   state_nxt = S_ANG;
      S_ANG:    state_nxt = S_SIN;
      S_SIN:    state_nxt = S_COS;
      S_COS:    state_nxt = S_UB;
      S_UB:     state_nxt = S_S3;
      S_S3:     state_nxt = S_S3B;
      S_S3B:    state_nxt = S_SUM;
      S_SUM:    state_nxt = S_DSTART;
      S_DSTART: if (div_start) state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_stat.done) begin
          state_nxt = (div_idx_r == 2'd2) ? S_OUT : S_DSTART;
        end
      end
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      supply_r     <= SUPPLY_RST;
      dlim_r       <= DLIM_RST;
      ppc_r        <= PPC_RST;
      offset_r     <= '0;
      mech_angle_r <= '0;
      div_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SUPPLY: supply_r <= cfg_wdata[5:0];
          REG_DLIM:   dlim_r   <= cfg_wdata[5:0];
          REG_PPC:    ppc_r    <= cfg_wdata[5:0];
          REG_OFFSET: offset_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_ADV) begin
        mech_angle_r <= mech_angle_r + step_hi_r + mul_p_r[31:0];
      end
      if (state_r == S_SUM) begin
        div_idx_r <= '0;
      end else if (state_r == S_DWAIT && div_stat.done) begin
        div_idx_r <= div_idx_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (in_take) begin
      vel_r <= in_target_velocity;
      dt_r  <= dt_sel;
    end
    case (state_r)
      S_LO:  rate_hi_r <= mul_p_r[63:32];
      S_HI:  step_hi_r <= mul_p_r[63:32];
      S_ANG: el_r      <= mul_p_r[31:0] + {offset_r, 16'b0};
      S_SIN: tab_r     <= sine_q16(el_r);
      S_COS: tab_r     <= sine_q16(el_r + QUARTER);
      S_UB:  ualpha_r  <= -$signed(mul_p_r[VOLT_W-1:0]);
      S_S3B: s3b_r     <= $signed(prod_adj[VOLT_W+15:16]);
      S_SUM: begin
        ph_r[0] <= ph_a_nxt;
        ph_r[1] <= ph_b_nxt;
        ph_r[2] <= ph_c_nxt;
      end
      default: ;
    endcase
    if (state_r == S_DWAIT && div_stat.done) begin
      duty_r[div_idx_r] <= div_duty;
    end
    if (out_load) begin
      out_a_r  <= duty_r[0];
      out_b_r  <= duty_r[1];
      out_c_r  <= duty_r[2];
      out_uq_r <= dlim_r;
    end
  end

  olfoc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .volt  (ph_r[div_idx_r]),
    .full  ({supply_r, 16'b0}),
    .stat  (div_stat),
    .duty  (div_duty)
  );

  assign out_valid        = out_valid_r;
  assign out_duty_phase_a = out_a_r;
  assign out_duty_phase_b = out_b_r;
  assign out_duty_phase_c = out_c_r;
  assign out_applied_uq   = out_uq_r;

endmodule

// ----- sv/olfoc_chk.sv -----
// ---------------------------------------------------------------------------
// Open-loop FOC phase duty: port checker
// Watches the top-level channels over time; attached by bind.
// ---------------------------------------------------------------------------
`include "open_loop_foc_phase_duty_defines.svh"

module olfoc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_duty_phase_a,
  input logic [7:0] out_duty_phase_b,
  input logic [7:0] out_duty_phase_c,
  input logic [5:0] out_applied_uq
);

  // hold a stalled result
  `OLFOC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_duty_phase_a) && $stable(out_duty_phase_b) && $stable(out_duty_phase_c) && $stable(out_applied_uq))

  // busy right after a transaction is taken
  `OLFOC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

  // a new result comes with the sequencer back at idle
  `OLFOC_ASSERT_SAME(a_ready_on_result, clk, rst_n, $rose(out_valid), in_ready)

endmodule

bind open_loop_foc_phase_duty olfoc_chk u_olfoc_chk (.*);

// ----- dv/olfoc_duty_checker.sv -----
// ---------------------------------------------------------------------------
// Open-loop FOC phase duty: transaction checker
// Watches the configuration port and both channels, keeps its own copy of the
// registers and the rotor angle, predicts the three duties and the applied Uq
// for every accepted tick and compares each accepted result in order.
// ---------------------------------------------------------------------------
module olfoc_duty_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [31:0]       in_target_velocity,
  input  logic [31:0]       in_elapsed_us,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_duty_phase_a,
  input  logic [7:0]        out_duty_phase_b,
  input  logic [7:0]        out_duty_phase_c,
  input  logic [5:0]        out_applied_uq,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  output int unsigned       mismatch_cnt,
  output int unsigned       pending_cnt
);
  import olfoc_pkg::*;

  localparam int     LUT_BITS      = SINE_TABLE_BITS;
  localparam int     LUT_N         = 1 << LUT_BITS;
  localparam longint RATE_PER_RAD  = 44798134;
  localparam longint ROOT3_Q16     = 113512;
  localparam logic [31:0] TICK_MAX_US  = 32'd500000;
  localparam logic [31:0] TICK_DFLT_US = 32'd1000;
  localparam longint POLY_K1 = 1686629713;
  localparam longint POLY_K3 = -693598670;
  localparam longint POLY_K5 = 85569306;
  localparam longint POLY_K7 = -5026996;
  localparam longint POLY_K9 = 172273;

  typedef struct packed {
    logic [7:0] ph_a;
    logic [7:0] ph_b;
    logic [7:0] ph_c;
    logic [5:0] uq;
  } duty_set_t;

  duty_set_t   expected_duties [$];
  longint      sine_lut [0:LUT_N];
  logic [5:0]  bus_volts;
  logic [5:0]  uq_volts;
  logic [5:0]  pp_setting;
  logic [15:0] zero_offset;
  logic [31:0] rotor_angle;

  function automatic longint q30_product(input longint a, input longint b);
    longint ma;
    longint mb;
    longint p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = (ma * mb) >>> 30;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint lut_point(input int i);
    longint x;
    longint x2;
    longint acc;
    x   = longint'(i) <<< (30 - LUT_BITS);
    x2  = q30_product(x, x);
    acc = POLY_K7 + q30_product(POLY_K9, x2);
    acc = POLY_K5 + q30_product(acc, x2);
    acc = POLY_K3 + q30_product(acc, x2);
    acc = POLY_K1 + q30_product(acc, x2);
    acc = q30_product(acc, x);
    if (acc < 0) acc = 0;
    acc = (acc + 8192) / 16384;
    return (acc > 65536) ? 65536 : acc;
  endfunction

  initial begin
    for (int i = 0; i <= LUT_N; i++) sine_lut[i] = lut_point(i);
  end

  function automatic longint angle_sine(input logic [31:0] ang);
    int unsigned pos;
    longint      mag;
    pos = ang[29 -: LUT_BITS];
    if (ang[30]) pos = LUT_N - pos;
    mag = sine_lut[pos];
    return ang[31] ? -mag : mag;
  endfunction

  function automatic logic [7:0] duty_byte(input longint u, input longint full);
    longint v;
    if (full <= 0) return 8'd0;
    v = (u < 0) ? 0 : ((u > full) ? full : u);
    return 8'((v * 255) / full);
  endfunction

  // advance the rotor angle and work out the duties for one tick
  function automatic duty_set_t predict_duties(input logic [31:0] vel_bits,
                                               input logic [31:0] dt_raw);
    duty_set_t   r;
    logic [31:0] dt;
    logic [63:0] rate;
    logic [63:0] stride;
    logic [31:0] el;
    longint      uq, s, c, ualpha, ubeta, s3b, half, full;
    dt = (dt_raw == 0 || dt_raw > TICK_MAX_US) ? TICK_DFLT_US : dt_raw;
    rate   = 64'(longint'($signed(vel_bits)) * RATE_PER_RAD);
    stride = rate * {32'd0, dt};
    rotor_angle = rotor_angle + stride[63:32];
    el = rotor_angle * {26'd0, pp_setting} + {zero_offset, 16'h0000};
    s  = angle_sine(el);
    c  = angle_sine(el + 32'h4000_0000);
    uq     = longint'(uq_volts) * 65536;
    ualpha = -((uq * s) / 65536);
    ubeta  = (uq * c) / 65536;
    s3b    = (ROOT3_Q16 * ubeta) / 65536;
    half   = longint'(bus_volts) * 32768;
    full   = longint'(bus_volts) * 65536;
    r.ph_a = duty_byte(ualpha + half, full);
    r.ph_b = duty_byte((s3b - ualpha) / 2 + half, full);
    r.ph_c = duty_byte((-ualpha - s3b) / 2 + half, full);
    r.uq   = uq_volts;
    return r;
  endfunction

  initial mismatch_cnt = 0;
  initial pending_cnt  = 0;

  always @(posedge clk) begin : watch
    duty_set_t want;
    if (!rst_n) begin
      bus_volts   = SUPPLY_RST;
      uq_volts    = DLIM_RST;
      pp_setting  = PPC_RST;
      zero_offset = 16'd0;
      rotor_angle = 32'd0;
      expected_duties.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SUPPLY: bus_volts   = cfg_wdata[5:0];
          REG_DLIM:   uq_volts    = cfg_wdata[5:0];
          REG_PPC:    pp_setting  = cfg_wdata[5:0];
          REG_OFFSET: zero_offset = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_duties.size() == 0) begin
          $error("unexpected result transaction: a=%0d b=%0d c=%0d uq=%0d",
                 out_duty_phase_a, out_duty_phase_b, out_duty_phase_c, out_applied_uq);
          mismatch_cnt++;
        end else begin
          want = expected_duties.pop_front();
          if (out_duty_phase_a !== want.ph_a) begin
            $error("duty_phase_a: expected %0d, got %0d", want.ph_a, out_duty_phase_a);
            mismatch_cnt++;
          end
          if (out_duty_phase_b !== want.ph_b) begin
            $error("duty_phase_b: expected %0d, got %0d", want.ph_b, out_duty_phase_b);
            mismatch_cnt++;
          end
          if (out_duty_phase_c !== want.ph_c) begin
            $error("duty_phase_c: expected %0d, got %0d", want.ph_c, out_duty_phase_c);
            mismatch_cnt++;
          end
          if (out_applied_uq !== want.uq) begin
            $error("applied_uq: expected %0d, got %0d", want.uq, out_applied_uq);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_duties.push_back(predict_duties(in_target_velocity, in_elapsed_us));
    end
    pending_cnt <= expected_duties.size();
  end

endmodule

// ----- dv/open_loop_foc_phase_duty_tb.sv -----
// ---------------------------------------------------------------------------
// Open-loop FOC phase duty: testbench top
// Drives control ticks and register settings into the duty generator with
// random sender gaps and receiver stalls; a checker beside the block predicts
// and compares every result transaction. Directed ticks cover the velocity
// and elapsed-time extremes, the time-step fallback, zero supply, zero pole
// pairs and zero drive limit, then random ticks run across many settings.
// ---------------------------------------------------------------------------
module open_loop_foc_phase_duty_tb;
  import olfoc_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_PHASES  = 12;
  localparam int TICKS_PER_PHASE = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_target_velocity = '0;
  logic [31:0] in_elapsed_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_duty_phase_a;
  logic [7:0]  out_duty_phase_b;
  logic [7:0]  out_duty_phase_c;
  logic [5:0]  out_applied_uq;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned tick_cnt = 0;
  int unsigned setting_cnt = 0;
  int unsigned rx_hold = 0;
  bit          tx_gap_on = 1'b1;
  bit          rx_stall_on = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  open_loop_foc_phase_duty u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_target_velocity(in_target_velocity), .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_duty_phase_a(out_duty_phase_a), .out_duty_phase_b(out_duty_phase_b),
    .out_duty_phase_c(out_duty_phase_c), .out_applied_uq(out_applied_uq),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  olfoc_duty_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_target_velocity(in_target_velocity), .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_duty_phase_a(out_duty_phase_a), .out_duty_phase_b(out_duty_phase_b),
    .out_duty_phase_c(out_duty_phase_c), .out_applied_uq(out_applied_uq),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatch_cnt(mismatch_cnt), .pending_cnt(pending_cnt)
  );

  // receiver: stall a random number of cycles after each transaction
  always @(posedge clk) begin : rx_side
    int unsigned draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && out_ready) begin
      draw = rx_stall_on ? $urandom_range(0, 14) : 0;
      rx_hold   <= draw;
      out_ready <= (draw == 0);
    end else if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_tick(input logic [31:0] vel, input logic [31:0] dt);
    int unsigned gap;
    gap = tx_gap_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_target_velocity <= vel;
    in_elapsed_us      <= dt;
    do @(posedge clk); while (!in_ready);
    tick_cnt++;
  endtask

  // hold off until every expected result has come, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [5:0] vbus, input logic [5:0] ulim,
                              input logic [5:0] pp, input logic [15:0] zoff);
    logic [1:0]  idx [4];
    logic [15:0] word [4];
    idx  = '{REG_SUPPLY, REG_DLIM, REG_PPC, REG_OFFSET};
    word = '{{10'($urandom), vbus}, {10'($urandom), ulim}, {10'($urandom), pp}, zoff};
    wait_idle();
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= word[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    setting_cnt++;
  endtask

  task automatic random_tick();
    logic [31:0] v;
    logic [31:0] dt;
    v = $urandom;
    case ($urandom_range(0, 3))
      2: v = {{12{v[31]}}, v[19:0]};
      3: v = {{16{v[31]}}, v[15:0]};
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: dt = 32'd0;
      1: dt = $urandom;
      2: dt = $urandom_range(499998, 500002);
      3, 4, 5: dt = $urandom_range(1, 500000);
      default: dt = $urandom_range(1, 2000);
    endcase
    send_tick(v, dt);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults after reset, time-step fallback and velocity extremes
    send_tick(32'd0, 32'd0);
    send_tick(32'h7fff_ffff, 32'd500000);
    send_tick(32'h8000_0000, 32'd500001);
    send_tick(32'd1, 32'hffff_ffff);
    send_tick(32'hffff_ffff, 32'd1);
    send_tick(32'h0001_0000, 32'd1000);

    program_regs(6'd63, 6'd63, 6'd63, 16'hffff);
    send_tick(32'h7fff_ffff, 32'd500000);
    send_tick(32'h8000_0000, 32'd499999);
    send_tick($urandom, 32'd1);

    // zero supply
    program_regs(6'd0, 6'd20, 6'd3, 16'h4000);
    send_tick(32'h0123_4567, 32'd700);
    send_tick(32'hfedc_ba98, 32'd0);

    // zero pole pairs
    program_regs(6'd5, 6'd10, 6'd0, 16'h1234);
    send_tick(32'h0040_0000, 32'd2500);
    send_tick(32'hffc0_0000, 32'd40000);

    // zero drive limit at a 1 V supply
    program_regs(6'd1, 6'd0, 6'd1, 16'h0000);
    send_tick(32'h0100_0000, 32'd1000);
    send_tick(32'h8000_0001, 32'd12345);

    // drive limit far above supply, so the phases clamp
    program_regs(6'd1, 6'd63, 6'd1, 16'h8000);
    send_tick(32'h0200_0000, 32'd333);
    send_tick(32'h7654_3210, 32'd99999);

    for (int p = 0; p < RAND_PHASES; p++) begin
      program_regs(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)), 16'($urandom));
      tx_gap_on   = (p % 4) < 2;
      rx_stall_on = (p % 2) == 0;
      repeat (TICKS_PER_PHASE) random_tick();
    end

    wait_idle();
    $display("Ran %0d control ticks over %0d register settings", tick_cnt, setting_cnt);
    $display("with random sender gaps, receiver stalls and back-to-back stretches.");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
